@@ hdl/gpcc_pkg.sv @@
package gpcc_pkg;

    localparam int MAX_COMPONENTS = 8;
    localparam int COLOR_BITS     = 16;
    localparam int IDX_W          = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
    localparam int DIFF_W         = COLOR_BITS + 1;
    localparam int PROD_W         = 34;
    localparam int HALF_W         = PROD_W / 2;
    localparam int MUL_A_W        = HALF_W + 1;
    localparam int MUL_W          = MUL_A_W + 32;
    localparam int ACC_W          = 70;
    localparam int SCORE_W        = 32;
    localparam int CHAIN_CNT_W    = $clog2(MAX_COMPONENTS + 1);

    // table word codes
    localparam logic [3:0] WORD_MEAN_LAST = 4'd2;
    localparam logic [3:0] WORD_INV_FIRST = 4'd3;
    localparam logic [3:0] WORD_INV_LAST  = 4'd11;
    localparam logic [3:0] WORD_LOG_DET   = 4'd12;
    localparam logic [3:0] WORD_USABLE    = 4'd13;

    // multiply phases of one quadratic-form term
    localparam logic [1:0] PH_DIFF = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  comp;
        logic [3:0]        word;
        logic [31:0]       value;
    } load_t;

    typedef struct packed {
        logic       start;
        logic       run;
        logic [1:0] phase;
        logic [1:0] ti;
        logic [1:0] tj;
        logic       finish;
    } step_t;

    typedef struct packed {
        logic                      found;
        logic [IDX_W-1:0]          idx;
        logic signed [SCORE_W-1:0] score;
    } chain_t;

endpackage

@@ hdl/gmm_pixel_component_classifier.sv @@
// classifies pixels against a stored gaussian mixture. a load transfer (mode 1) writes
// one table word and returns nothing; a pixel transfer returns one result: -1 when
// the pixel is unselected, else the usable active component of least score
// d + ln(det), lower index on ties, index 0 with none_usable set when none is usable.
// each component lives in its own cell with one 18x32 multiplier; a selected pixel
// latches its differences as the transfer is taken, then runs nine terms of three
// products each, forms the score, and lets the best candidate ripple down the cell
// row; the result enters the output register once that register is free. a load
// writes its word as the transfer is taken; an unselected pixel's result shows in
// the cycle after its transfer. usable flags clear at reset.
module gmm_pixel_component_classifier (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               mode,
    input  logic [15:0]        red,
    input  logic [15:0]        green,
    input  logic [15:0]        blue,
    input  logic               pixel_selected,
    input  logic [2:0]         entry_component,
    input  logic [3:0]         entry_word,
    input  logic signed [31:0] entry_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [3:0]  component,
    output logic               none_usable
);

    typedef enum logic [1:0] {S_IDLE, S_CALC, S_FIN, S_CHAIN} state_t;

    state_t                                  state_reg;
    logic [1:0]                              phase_reg;
    logic [1:0]                              ti_reg;
    logic [1:0]                              tj_reg;
    logic [gpcc_pkg::CHAIN_CNT_W-1:0]        cnt_reg;
    logic [3:0]                              num_reg;
    logic                                    out_valid_reg;
    logic signed [3:0]                       component_reg;
    logic                                    none_usable_reg;

    logic                                    xfer;
    logic                                    out_free;
    logic                                    chain_done;
    logic                                    res_set;
    gpcc_pkg::load_t                         load;
    gpcc_pkg::step_t                         step;
    gpcc_pkg::chain_t                        chain [gpcc_pkg::MAX_COMPONENTS + 1];

    // output register frees when empty or being taken
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign xfer     = in_valid && in_ready;

    // a new result enters the output register this cycle
    assign chain_done = (state_reg == S_CHAIN)
        && (cnt_reg == gpcc_pkg::CHAIN_CNT_W'(gpcc_pkg::MAX_COMPONENTS));
    assign res_set    = (xfer && !mode && !pixel_selected) || (chain_done && out_free);

    assign load.we    = xfer && mode;
    assign load.comp  = gpcc_pkg::IDX_W'(entry_component);
    assign load.word  = entry_word;
    assign load.value = entry_value;

    assign step.start  = xfer && !mode && pixel_selected;
    assign step.run    = (state_reg == S_CALC);
    assign step.phase  = phase_reg;
    assign step.ti     = ti_reg;
    assign step.tj     = tj_reg;
    assign step.finish = (state_reg == S_FIN);

    assign chain[0] = '0;

    for (genvar k = 0; k < gpcc_pkg::MAX_COMPONENTS; k++)
    begin : g_cell
        gpcc_cell u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .idx            (gpcc_pkg::IDX_W'(k)),
            .num_components (num_reg),
            .load           (load),
            .step           (step),
            .px_r           (red[gpcc_pkg::COLOR_BITS-1:0]),
            .px_g           (green[gpcc_pkg::COLOR_BITS-1:0]),
            .px_b           (blue[gpcc_pkg::COLOR_BITS-1:0]),
            .chain_in       (chain[k]),
            .chain_out      (chain[k+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            phase_reg       <= gpcc_pkg::PH_DIFF;
            ti_reg          <= '0;
            tj_reg          <= '0;
            cnt_reg         <= '0;
            num_reg         <= 4'd8;
            out_valid_reg   <= 1'b0;
            component_reg   <= '0;
            none_usable_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                num_reg <= cfg_data;
            if (res_set)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (xfer && !mode)
                    begin
                        if (pixel_selected)
                        begin
                            state_reg <= S_CALC;
                            phase_reg <= gpcc_pkg::PH_DIFF;
                            ti_reg    <= '0;
                            tj_reg    <= '0;
                        end
                        else
                        begin
                            // unselected pixel answers at once
                            component_reg   <= -4'sd1;
                            none_usable_reg <= 1'b0;
                        end
                    end
                end
                S_CALC:
                begin
                    // three products per term, nine terms
                    if (phase_reg == gpcc_pkg::PH_LOW)
                    begin
                        phase_reg <= gpcc_pkg::PH_DIFF;
                        if (tj_reg == 2'd2)
                        begin
                            tj_reg <= '0;
                            if (ti_reg == 2'd2)
                                state_reg <= S_FIN;
                            else
                                ti_reg <= ti_reg + 2'd1;
                        end
                        else
                            tj_reg <= tj_reg + 2'd1;
                    end
                    else
                        phase_reg <= phase_reg + 2'd1;
                end
                S_FIN:
                begin
                    state_reg <= S_CHAIN;
                    cnt_reg   <= '0;
                end
                S_CHAIN:
                begin
                    // best candidate moves one cell per cycle
                    if (chain_done)
                    begin
                        if (out_free)
                        begin
                            state_reg       <= S_IDLE;
                            none_usable_reg <= !chain[gpcc_pkg::MAX_COMPONENTS].found;
                            component_reg   <= chain[gpcc_pkg::MAX_COMPONENTS].found
                                ? 4'(chain[gpcc_pkg::MAX_COMPONENTS].idx) : 4'sd0;
                        end
                    end
                    else
                        cnt_reg <= cnt_reg + gpcc_pkg::CHAIN_CNT_W'(1);
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign component   = component_reg;
    assign none_usable = none_usable_reg;

endmodule

@@ hdl/gpcc_cell.sv @@
module gpcc_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [gpcc_pkg::IDX_W-1:0]        idx,
    input  logic [3:0]                        num_components,
    input  gpcc_pkg::load_t                   load,
    input  gpcc_pkg::step_t                   step,
    input  logic [gpcc_pkg::COLOR_BITS-1:0]   px_r,
    input  logic [gpcc_pkg::COLOR_BITS-1:0]   px_g,
    input  logic [gpcc_pkg::COLOR_BITS-1:0]   px_b,
    input  gpcc_pkg::chain_t                  chain_in,
    output gpcc_pkg::chain_t                  chain_out
);

    logic [gpcc_pkg::COLOR_BITS-1:0]              mean_reg [3];
    logic signed [31:0]                           inv_reg [9];
    logic signed [31:0]                           log_det_reg;
    logic                                         usable_reg;
    logic signed [gpcc_pkg::DIFF_W-1:0]           x_reg [3];
    logic signed [gpcc_pkg::PROD_W-1:0]           p_reg;
    logic signed [gpcc_pkg::ACC_W-1:0]            acc_reg;
    logic signed [gpcc_pkg::ACC_W-1:0]            acc_next;
    logic signed [gpcc_pkg::SCORE_W-1:0]          score_reg;
    gpcc_pkg::chain_t                             chain_reg;

    logic signed [gpcc_pkg::MUL_A_W-1:0]          mul_a;
    logic signed [31:0]                           mul_b;
    logic signed [gpcc_pkg::MUL_W-1:0]            mul;
    logic signed [gpcc_pkg::DIFF_W-1:0]           xi;
    logic signed [gpcc_pkg::DIFF_W-1:0]           xj;
    logic signed [31:0]                           inv_sel;
    logic [3:0]                                   inv_addr;
    logic signed [39:0]                           sum40;
    logic signed [gpcc_pkg::SCORE_W-1:0]          sat;
    logic                                         active;
    logic                                         here;

    assign here     = load.we && (load.comp == idx);
    assign xi       = x_reg[step.ti];
    assign xj       = x_reg[step.tj];
    // the term sum is symmetric, so entry (tj,ti) pairs with term (ti,tj)
    assign inv_addr = 4'(step.tj) * 4'd3 + 4'(step.ti);
    assign inv_sel  = inv_reg[inv_addr];

    always_comb
    begin
        case (step.phase)
            gpcc_pkg::PH_DIFF:
            begin
                mul_a = gpcc_pkg::MUL_A_W'(xi);
                mul_b = 32'(xj);
            end
            gpcc_pkg::PH_HIGH:
            begin
                mul_a = gpcc_pkg::MUL_A_W'($signed(p_reg[gpcc_pkg::PROD_W-1:gpcc_pkg::HALF_W]));
                mul_b = inv_sel;
            end
            gpcc_pkg::PH_LOW:
            begin
                mul_a = {1'b0, p_reg[gpcc_pkg::HALF_W-1:0]};
                mul_b = inv_sel;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul = mul_a * mul_b;

    always_comb
    begin
        case (step.phase)
            gpcc_pkg::PH_HIGH: acc_next = acc_reg
                + (gpcc_pkg::ACC_W'(mul) <<< gpcc_pkg::HALF_W);
            gpcc_pkg::PH_LOW:  acc_next = acc_reg + gpcc_pkg::ACC_W'(mul);
            default:           acc_next = acc_reg;
        endcase
    end

    // floor of the sum to q16.16, plus log det, clamped to 32 bits
    assign sum40 = 40'($signed(acc_reg[gpcc_pkg::ACC_W-1:32])) + 40'(log_det_reg);
    always_comb
    begin
        if (sum40 > 40'sd2147483647)
            sat = 32'sh7fffffff;
        else if (sum40 < -40'sd2147483648)
            sat = 32'sh80000000;
        else
            sat = sum40[31:0];
    end

    assign active = usable_reg && (4'(idx) < num_components);

    always_ff @(posedge clk)
    begin
        if (here && load.word <= gpcc_pkg::WORD_MEAN_LAST)
            mean_reg[load.word[1:0]] <= load.value[gpcc_pkg::COLOR_BITS-1:0];
        if (here && load.word >= gpcc_pkg::WORD_INV_FIRST
                 && load.word <= gpcc_pkg::WORD_INV_LAST)
            inv_reg[load.word - gpcc_pkg::WORD_INV_FIRST] <= load.value;
        if (here && load.word == gpcc_pkg::WORD_LOG_DET)
            log_det_reg <= load.value;
        if (step.start)
        begin
            x_reg[0] <= $signed({1'b0, px_r}) - $signed({1'b0, mean_reg[0]});
            x_reg[1] <= $signed({1'b0, px_g}) - $signed({1'b0, mean_reg[1]});
            x_reg[2] <= $signed({1'b0, px_b}) - $signed({1'b0, mean_reg[2]});
            acc_reg  <= '0;
        end
        else if (step.run)
        begin
            if (step.phase == gpcc_pkg::PH_DIFF)
                p_reg <= gpcc_pkg::PROD_W'(mul) <<< (32 - 2 * gpcc_pkg::COLOR_BITS);
            acc_reg <= acc_next;
        end
        if (step.finish)
            score_reg <= sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            usable_reg <= 1'b0;
            chain_reg  <= '0;
        end
        else
        begin
            if (here && load.word == gpcc_pkg::WORD_USABLE)
                usable_reg <= load.value[0];
            if (active && (!chain_in.found || score_reg < chain_in.score))
            begin
                chain_reg.found <= 1'b1;
                chain_reg.idx   <= idx;
                chain_reg.score <= score_reg;
            end
            else
                chain_reg <= chain_in;
        end
    end

    assign chain_out = chain_reg;

endmodule

@@ hdl/gpcc_checker.sv @@
module gpcc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic signed [3:0] component,
    input logic              none_usable
);

    // a waiting result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(component) && $stable(none_usable))
        else $error("result changed while stalled");

    // no new transfer while a result is stuck
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    // unselected answer never flags none usable
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && component == -4'sd1 |-> !none_usable)
        else $error("unselected result flagged none usable");

    // none usable always reports index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && none_usable |-> component == 4'sd0)
        else $error("none usable with nonzero index");

endmodule

bind gmm_pixel_component_classifier gpcc_checker u_gpcc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .component   (component),
    .none_usable (none_usable)
);
